[hw/rtl/amp_pkg.sv]
// Shared register indexes and reset values for the affine modular permutation core.
`default_nettype none
package amp_pkg;

    typedef enum logic [1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_MULTIPLIER = 2'd1,
        CFG_OFFSET     = 2'd2,
        CFG_INVERSE    = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_FORWARD = 1'b0,
        OP_INVERSE = 1'b1
    } op_t;

    localparam logic [30:0] RESET_MODULUS    = 31'd48773177;
    localparam logic [30:0] RESET_MULTIPLIER = 31'd48771253;
    localparam logic [30:0] RESET_OFFSET     = 31'd38748171;
    localparam logic [30:0] RESET_INVERSE    = 31'd39368370;

endpackage
`default_nettype wire

[hw/rtl/affine_modular_permutation_core.sv]
// Top level of the affine modular permutation core: config registers and the cell chains.
`default_nettype none
// Maps value to (value*multiplier + offset) mod modulus (operation 0) or to
// ((value - offset) mod modulus) * inverse_multiplier mod modulus (operation 1).
// A new request is accepted every cycle unless out_ready holds back the pipeline; each
// request passes through the chain of reduction cells (one input bit per cell), a
// combine stage, the chain of multiply cells (one multiplier bit per cell) and a
// final stage.
// Each stage stalls only when it is full and its successor is stalled. Write the
// registers only while no request is in flight; the inverse multiplier is taken
// as given. A zero modulus yields zero.
module affine_modular_permutation_core
    import amp_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MOD_BITS   = 31
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [MOD_BITS-1:0]   cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  operation,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [MOD_BITS-1:0]        mapped
);

    localparam int MW = MOD_BITS;
    localparam int RN = (VALUE_BITS > MOD_BITS) ? VALUE_BITS : MOD_BITS;

    logic [MW-1:0] modulus_reg, multiplier_reg, offset_reg, inverse_reg;

    // Latch configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg    <= RESET_MODULUS[MW-1:0];
            multiplier_reg <= RESET_MULTIPLIER[MW-1:0];
            offset_reg     <= RESET_OFFSET[MW-1:0];
            inverse_reg    <= RESET_INVERSE[MW-1:0];
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODULUS:    modulus_reg    <= cfg_data;
                CFG_MULTIPLIER: multiplier_reg <= cfg_data;
                CFG_OFFSET:     offset_reg     <= cfg_data;
                CFG_INVERSE:    inverse_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Reduction chain: value, offset and the chosen multiplier mod m
    logic          r_valid [RN+1];
    logic          r_ready [RN+1];
    logic          r_op    [RN+1];
    logic [RN-1:0] r_sv    [RN+1];
    logic [RN-1:0] r_ss    [RN+1];
    logic [RN-1:0] r_sx    [RN+1];
    logic [MW-1:0] r_rv    [RN+1];
    logic [MW-1:0] r_rs    [RN+1];
    logic [MW-1:0] r_rx    [RN+1];

    assign r_valid[0] = in_valid;
    assign in_ready   = r_ready[0];
    assign r_op[0]    = operation;
    assign r_sv[0]    = RN'(value);
    assign r_ss[0]    = RN'(offset_reg);
    assign r_sx[0]    = RN'((operation == OP_INVERSE) ? inverse_reg : multiplier_reg);
    assign r_rv[0]    = '0;
    assign r_rs[0]    = '0;
    assign r_rx[0]    = '0;

    for (genvar i = 0; i < RN; i++)
    begin : g_red
        amp_red_cell #(.MW(MW), .RN(RN)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .m         (modulus_reg),
            .in_valid  (r_valid[i]),
            .in_ready  (r_ready[i]),
            .in_op     (r_op[i]),
            .in_sv     (r_sv[i]),
            .in_ss     (r_ss[i]),
            .in_sx     (r_sx[i]),
            .in_rv     (r_rv[i]),
            .in_rs     (r_rs[i]),
            .in_rx     (r_rx[i]),
            .out_valid (r_valid[i+1]),
            .out_ready (r_ready[i+1]),
            .out_op    (r_op[i+1]),
            .out_sv    (r_sv[i+1]),
            .out_ss    (r_ss[i+1]),
            .out_sx    (r_sx[i+1]),
            .out_rv    (r_rv[i+1]),
            .out_rs    (r_rs[i+1]),
            .out_rx    (r_rx[i+1])
        );
    end

    // Combine stage: pick value residue or its difference with the offset
    logic          cmb_valid_reg, cmb_op_reg, cmb_ready_dn, cmb_ready;
    logic [MW-1:0] cmb_a_reg, cmb_x_reg, cmb_s_reg;
    logic [MW:0]   diff;
    logic [MW-1:0] cmb_a_next;

    always_comb
    begin
        if (r_rv[RN] >= r_rs[RN])
        begin
            diff = {1'b0, r_rv[RN]} - {1'b0, r_rs[RN]};
        end
        else
        begin
            diff = {1'b0, r_rv[RN]} + {1'b0, modulus_reg} - {1'b0, r_rs[RN]};
        end
        cmb_a_next = (r_op[RN] == OP_INVERSE) ? diff[MW-1:0] : r_rv[RN];
    end

    assign cmb_ready  = !cmb_valid_reg || cmb_ready_dn;
    assign r_ready[RN] = cmb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmb_valid_reg <= 1'b0;
        end
        else if (cmb_ready)
        begin
            cmb_valid_reg <= r_valid[RN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmb_ready && r_valid[RN])
        begin
            cmb_op_reg <= r_op[RN];
            cmb_a_reg  <= cmb_a_next;
            cmb_x_reg  <= r_rx[RN];
            cmb_s_reg  <= r_rs[RN];
        end
    end

    // Multiply chain: a * x mod m, one bit of x per cell
    logic          m_valid [MW+1];
    logic          m_ready [MW+1];
    logic          m_op    [MW+1];
    logic [MW-1:0] m_acc   [MW+1];
    logic [MW-1:0] m_a     [MW+1];
    logic [MW-1:0] m_xs    [MW+1];
    logic [MW-1:0] m_s     [MW+1];

    assign m_valid[0]   = cmb_valid_reg;
    assign cmb_ready_dn = m_ready[0];
    assign m_op[0]      = cmb_op_reg;
    assign m_acc[0]     = '0;
    assign m_a[0]       = cmb_a_reg;
    assign m_xs[0]      = cmb_x_reg;
    assign m_s[0]       = cmb_s_reg;

    for (genvar j = 0; j < MW; j++)
    begin : g_mul
        amp_mul_cell #(.MW(MW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .m         (modulus_reg),
            .in_valid  (m_valid[j]),
            .in_ready  (m_ready[j]),
            .in_op     (m_op[j]),
            .in_acc    (m_acc[j]),
            .in_a      (m_a[j]),
            .in_xs     (m_xs[j]),
            .in_s      (m_s[j]),
            .out_valid (m_valid[j+1]),
            .out_ready (m_ready[j+1]),
            .out_op    (m_op[j+1]),
            .out_acc   (m_acc[j+1]),
            .out_a     (m_a[j+1]),
            .out_xs    (m_xs[j+1]),
            .out_s     (m_s[j+1])
        );
    end

    // Final stage: add the offset on the forward map, reduce, zero on zero modulus
    logic          fin_valid_reg, fin_ready;
    logic [MW-1:0] fin_reg, fin_next;
    logic [MW:0]   sum;

    always_comb
    begin
        sum = {1'b0, m_acc[MW]}
            + ((m_op[MW] == OP_FORWARD) ? {1'b0, m_s[MW]} : '0);
        if (sum >= {1'b0, modulus_reg})
        begin
            sum = sum - {1'b0, modulus_reg};
        end
        fin_next = (modulus_reg == '0) ? '0 : sum[MW-1:0];
    end

    assign fin_ready   = !fin_valid_reg || out_ready;
    assign m_ready[MW] = fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            fin_valid_reg <= m_valid[MW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && m_valid[MW])
        begin
            fin_reg <= fin_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign mapped    = fin_reg;

    // Combine stage holds its request while the multiply chain is stalled
    a_cmb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmb_valid_reg && !cmb_ready_dn |=> cmb_valid_reg && $stable(cmb_a_reg))
        else $error("combine stage lost a stalled request");

    // An accepted request occupies the first reduction cell next cycle
    a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> r_valid[1])
        else $error("accepted request missing from first cell");

    // Final stage keeps its result while the consumer is stalled
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && !out_ready |=> fin_valid_reg && $stable(fin_reg))
        else $error("final stage dropped a stalled result");

endmodule
`default_nettype wire

[hw/rtl/amp_red_cell.sv]
// One reduction cell: folds one bit of each of three operands into its residue mod m.
`default_nettype none
module amp_red_cell #(
    parameter int MW = 31,
    parameter int RN = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [MW-1:0] m,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_op,
    input  wire logic [RN-1:0] in_sv,
    input  wire logic [RN-1:0] in_ss,
    input  wire logic [RN-1:0] in_sx,
    input  wire logic [MW-1:0] in_rv,
    input  wire logic [MW-1:0] in_rs,
    input  wire logic [MW-1:0] in_rx,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               out_op,
    output logic [RN-1:0]      out_sv,
    output logic [RN-1:0]      out_ss,
    output logic [RN-1:0]      out_sx,
    output logic [MW-1:0]      out_rv,
    output logic [MW-1:0]      out_rs,
    output logic [MW-1:0]      out_rx
);

    logic              valid_reg;
    logic              op_reg;
    logic [RN-1:0]     sv_reg, ss_reg, sx_reg;
    logic [MW-1:0]     rv_reg, rs_reg, rx_reg;
    logic [MW-1:0]     rv_next, rs_next, rx_next;
    logic [MW:0]       tv, ts, tx;
    logic [MW:0]       mx;

    // Shift the next bit into each residue and subtract m once if needed
    always_comb
    begin
        mx = {1'b0, m};
        tv = {in_rv, in_sv[RN-1]};
        ts = {in_rs, in_ss[RN-1]};
        tx = {in_rx, in_sx[RN-1]};
        if (tv >= mx)
        begin
            tv = tv - mx;
        end
        if (ts >= mx)
        begin
            ts = ts - mx;
        end
        if (tx >= mx)
        begin
            tx = tx - mx;
        end
        rv_next = tv[MW-1:0];
        rs_next = ts[MW-1:0];
        rx_next = tx[MW-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    // Hold the stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg <= in_op;
            sv_reg <= {in_sv[RN-2:0], 1'b0};
            ss_reg <= {in_ss[RN-2:0], 1'b0};
            sx_reg <= {in_sx[RN-2:0], 1'b0};
            rv_reg <= rv_next;
            rs_reg <= rs_next;
            rx_reg <= rx_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_sv    = sv_reg;
    assign out_ss    = ss_reg;
    assign out_sx    = sx_reg;
    assign out_rv    = rv_reg;
    assign out_rs    = rs_reg;
    assign out_rx    = rx_reg;

endmodule
`default_nettype wire

[hw/rtl/amp_mul_cell.sv]
// One multiply cell: one step of interleaved modular multiplication, MSB first.
`default_nettype none
module amp_mul_cell #(
    parameter int MW = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [MW-1:0] m,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_op,
    input  wire logic [MW-1:0] in_acc,
    input  wire logic [MW-1:0] in_a,
    input  wire logic [MW-1:0] in_xs,
    input  wire logic [MW-1:0] in_s,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               out_op,
    output logic [MW-1:0]      out_acc,
    output logic [MW-1:0]      out_a,
    output logic [MW-1:0]      out_xs,
    output logic [MW-1:0]      out_s
);

    logic          valid_reg;
    logic          op_reg;
    logic [MW-1:0] acc_reg, a_reg, xs_reg, s_reg;
    logic [MW-1:0] acc_next;
    logic [MW+1:0] t, mx;

    // Double the accumulator, add the multiplicand on a set bit, reduce twice
    always_comb
    begin
        mx = {2'b00, m};
        t  = {1'b0, in_acc, 1'b0} + (in_xs[MW-1] ? {2'b00, in_a} : '0);
        if (t >= mx)
        begin
            t = t - mx;
        end
        if (t >= mx)
        begin
            t = t - mx;
        end
        acc_next = t[MW-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    // Hold the stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg  <= in_op;
            acc_reg <= acc_next;
            a_reg   <= in_a;
            xs_reg  <= {in_xs[MW-2:0], 1'b0};
            s_reg   <= in_s;
        end
    end

    assign out_valid = valid_reg;
    assign out_op    = op_reg;
    assign out_acc   = acc_reg;
    assign out_a     = a_reg;
    assign out_xs    = xs_reg;
    assign out_s     = s_reg;

endmodule
`default_nettype wire
